// File: rtl/fjq_pkg.sv
// shared types and constants of the job queue
package fjq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF  = 16;
  localparam int unsigned LENGTH_WIDTH_DEF = 16;

  localparam int unsigned JOB_LEN_W = 16;
  localparam int unsigned TAG_W     = 16;
  localparam int unsigned OCC_W     = 5;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  localparam logic MODE_FIFO = 1'b0;
  localparam logic MODE_SJF  = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // broadcast to every cell of the chain
  typedef struct packed {
    logic enq;
    logic deq;
    logic sjf;
  } cell_ctrl_t;

endpackage

// File: rtl/fjq_if.sv
// handshake channels: job words in, result words out, mode register writes
interface fjq_job_if;
  import fjq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 cmd;
  logic [JOB_LEN_W-1:0] job_length;
  logic [TAG_W-1:0]     job_tag;
  modport source (output valid, cmd, job_length, job_tag, input ready);
  modport sink   (input valid, cmd, job_length, job_tag, output ready);
endinterface

interface fjq_res_if;
  import fjq_pkg::*;
  logic                 valid;
  logic                 ready;
  status_e              status;
  logic [JOB_LEN_W-1:0] out_job_length;
  logic [TAG_W-1:0]     out_job_tag;
  logic [OCC_W-1:0]     occupancy;
  modport source (output valid, status, out_job_length, out_job_tag, occupancy,
                  input ready);
  modport sink   (input valid, status, out_job_length, out_job_tag, occupancy,
                  output ready);
endinterface

interface fjq_cfg_if;
  logic valid;
  logic ready;
  logic queue_mode;
  modport source (output valid, queue_mode, input ready);
  modport sink   (input valid, queue_mode, output ready);
endinterface

// File: rtl/fjq_cell.sv
// one queue slot: holds an entry and trades it with its neighbors
module fjq_cell #(
  parameter int unsigned LENGTH_WIDTH = fjq_pkg::LENGTH_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  fjq_pkg::cell_ctrl_t     ctrl_i,
  input  logic [LENGTH_WIDTH-1:0] new_len_i,
  input  logic [fjq_pkg::TAG_W-1:0] new_tag_i,
  input  logic                    found_i,
  output logic                    found_o,
  input  logic                    left_valid_i,
  input  logic [LENGTH_WIDTH-1:0] left_len_i,
  input  logic [fjq_pkg::TAG_W-1:0] left_tag_i,
  input  logic                    right_valid_i,
  input  logic [LENGTH_WIDTH-1:0] right_len_i,
  input  logic [fjq_pkg::TAG_W-1:0] right_tag_i,
  output logic                    valid_o,
  output logic [LENGTH_WIDTH-1:0] len_o,
  output logic [fjq_pkg::TAG_W-1:0] tag_o
);
  import fjq_pkg::*;

  logic                    valid_q, valid_d;
  logic [LENGTH_WIDTH-1:0] len_q, len_d;
  logic [TAG_W-1:0]        tag_q, tag_d;
  logic                    greater;
  logic                    here;

  // strictly greater keeps equal lengths ahead of the new job
  assign greater = valid_q && ctrl_i.sjf && (len_q > new_len_i);
  assign here    = greater || !valid_q;
  assign found_o = found_i || here;

  always_comb begin
    valid_d = valid_q;
    len_d   = len_q;
    tag_d   = tag_q;
    if (ctrl_i.enq) begin
      if (found_i) begin
        // slot opened upstream: everything from here on moves one down
        valid_d = left_valid_i;
        len_d   = left_len_i;
        tag_d   = left_tag_i;
      end else if (here) begin
        valid_d = 1'b1;
        len_d   = new_len_i;
        tag_d   = new_tag_i;
      end
    end else if (ctrl_i.deq) begin
      valid_d = right_valid_i;
      len_d   = right_len_i;
      tag_d   = right_tag_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q <= len_d;
    tag_q <= tag_d;
  end

  assign valid_o = valid_q;
  assign len_o   = len_q;
  assign tag_o   = tag_q;

endmodule

// File: rtl/fifo_or_shortest_job_queue.sv
// Bounded job queue, FIFO or shortest-job-first order, built as a row of
// QUEUE_DEPTH slots with the head in slot 0. One word is taken per clock
// while the result output is not stalled; its result word appears in the
// output register on the next cycle and a new job word is taken while that
// result waits, as long as the waiting result is taken in the same cycle.
// The cycle time is set by the length compare in every slot and the insert
// flag that ripples down the row. After reset the queue is empty and in FIFO
// order. The mode register must be written only while idle; the block does not enforce it.
module fifo_or_shortest_job_queue #(
  parameter int unsigned QUEUE_DEPTH  = fjq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned LENGTH_WIDTH = fjq_pkg::LENGTH_WIDTH_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fjq_cfg_if.sink      cfg_i,
  fjq_job_if.sink      job_i,
  fjq_res_if.source    res_o
);
  import fjq_pkg::*;

  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic                    mode_q;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    accept;
  logic                    full;
  logic                    empty;
  logic                    enq_go;
  logic                    deq_go;
  cell_ctrl_t              ctrl;
  logic [LENGTH_WIDTH-1:0] new_len;
  logic [LENGTH_WIDTH+JOB_LEN_W-1:0] len_in_wide;
  logic [LENGTH_WIDTH+JOB_LEN_W-1:0] len_out_wide;
  logic [CNT_W+OCC_W-1:0]  occ_wide;

  // index k+1 is slot k; both ends read as empty
  logic                    v_w   [QUEUE_DEPTH+2];
  logic [LENGTH_WIDTH-1:0] len_w [QUEUE_DEPTH+2];
  logic [TAG_W-1:0]        tag_w [QUEUE_DEPTH+2];
  logic                    found_w [QUEUE_DEPTH+1];

  logic                    res_valid_q;
  status_e                 status_q, status_d;
  logic [JOB_LEN_W-1:0]    olen_q, olen_d;
  logic [TAG_W-1:0]        otag_q, otag_d;
  logic [OCC_W-1:0]        occ_q, occ_d;

  // mode register
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_FIFO;
    end else if (cfg_i.valid) begin
      mode_q <= cfg_i.queue_mode;
    end
  end

  assign job_i.ready = !res_valid_q || res_o.ready;
  assign accept      = job_i.valid && job_i.ready;
  assign full        = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty       = (count_q == '0);
  assign enq_go      = accept && (job_i.cmd == CMD_ENQ) && !full;
  assign deq_go      = accept && (job_i.cmd == CMD_DEQ) && !empty;

  assign ctrl.enq = enq_go;
  assign ctrl.deq = deq_go;
  assign ctrl.sjf = (mode_q == MODE_SJF);

  assign len_in_wide = {{LENGTH_WIDTH{1'b0}}, job_i.job_length};
  assign new_len     = len_in_wide[LENGTH_WIDTH-1:0];

  assign v_w[0]               = 1'b0;
  assign len_w[0]             = '0;
  assign tag_w[0]             = '0;
  assign v_w[QUEUE_DEPTH+1]   = 1'b0;
  assign len_w[QUEUE_DEPTH+1] = '0;
  assign tag_w[QUEUE_DEPTH+1] = '0;
  assign found_w[0]           = 1'b0;

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_slot
    fjq_cell #(
      .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .new_len_i     (new_len),
      .new_tag_i     (job_i.job_tag),
      .found_i       (found_w[k]),
      .found_o       (found_w[k+1]),
      .left_valid_i  (v_w[k]),
      .left_len_i    (len_w[k]),
      .left_tag_i    (tag_w[k]),
      .right_valid_i (v_w[k+2]),
      .right_len_i   (len_w[k+2]),
      .right_tag_i   (tag_w[k+2]),
      .valid_o       (v_w[k+1]),
      .len_o         (len_w[k+1]),
      .tag_o         (tag_w[k+1])
    );
  end

  always_comb begin
    count_d = count_q;
    if (enq_go) begin
      count_d = count_q + 1'b1;
    end else if (deq_go) begin
      count_d = count_q - 1'b1;
    end
  end

  assign len_out_wide = {{JOB_LEN_W{1'b0}}, len_w[1]};
  assign occ_wide     = {{OCC_W{1'b0}}, count_d};

  always_comb begin
    status_d = ST_DONE;
    olen_d   = '0;
    otag_d   = '0;
    occ_d    = occ_wide[OCC_W-1:0];
    if (job_i.cmd == CMD_ENQ) begin
      if (full) begin
        status_d = ST_FULL;
      end
    end else if (empty) begin
      status_d = ST_EMPTY;
    end else begin
      olen_d = len_out_wide[JOB_LEN_W-1:0];
      otag_d = tag_w[1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      olen_q   <= olen_d;
      otag_q   <= otag_d;
      occ_q    <= occ_d;
    end
  end

  assign res_o.valid          = res_valid_q;
  assign res_o.status         = status_q;
  assign res_o.out_job_length = olen_q;
  assign res_o.out_job_tag    = otag_q;
  assign res_o.occupancy      = occ_q;

  // head slot holds an entry exactly when the count is nonzero
  a_head_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_w[1] == (count_q != '0))
    else $error("head slot valid disagrees with count");

  // tail slot holds an entry exactly when the queue is full
  a_tail_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_w[QUEUE_DEPTH] == full)
    else $error("tail slot valid disagrees with full");

  // an accepted enqueue always finds a slot somewhere in the row
  a_insert_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_go |-> found_w[QUEUE_DEPTH])
    else $error("enqueue found no slot");

  a_enq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    enq_go |=> count_q == CNT_W'($past(count_q) + 1'b1))
    else $error("count did not rise after enqueue");

  a_deq_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    deq_go |=> count_q == CNT_W'($past(count_q) - 1'b1))
    else $error("count did not fall after dequeue");

endmodule

// File: verif/fifo_or_shortest_job_queue_tb.sv
// testbench for the job queue: random job words checked against a queue model in both orders
`timescale 1ns / 1ps

module fifo_or_shortest_job_queue_tb;
  import fjq_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned TAIL_CYCLES = 16;
  localparam int unsigned PRINT_CAP   = 40;

  typedef enum logic [1:0] {
    ACT_JOB,
    ACT_MODE,
    ACT_DRAIN
  } step_kind_e;

  typedef struct packed {
    step_kind_e           kind;
    logic                 cmd;
    logic [JOB_LEN_W-1:0] len;
    logic [TAG_W-1:0]     tag;
    logic                 mode;
  } step_t;

  typedef struct packed {
    logic [JOB_LEN_W-1:0] len;
    logic [TAG_W-1:0]     tag;
  } job_entry_t;

  typedef struct packed {
    status_e              status;
    logic [JOB_LEN_W-1:0] len;
    logic [TAG_W-1:0]     tag;
    logic [OCC_W-1:0]     occ;
  } res_word_t;

  logic clk_i;
  logic rst_ni;

  fjq_cfg_if cfg_if ();
  fjq_job_if job_if ();
  fjq_res_if res_if ();

  fifo_or_shortest_job_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .job_i  (job_if),
    .res_o  (res_if)
  );

  step_t       pending[$];
  res_word_t   due_results[$];
  job_entry_t  shadow_q[$];
  logic        shadow_mode = MODE_FIFO;
  int unsigned mismatch_count = 0;
  int unsigned send_gap = 0;
  int unsigned sink_stall = 0;
  int unsigned quiet_cycles = 0;
  logic        calm_tail = 1'b0;
  logic [7:0]  cyc = '0;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  always @(posedge clk_i) cyc <= cyc + 8'd1;

  // applies one job word to the shadow queue and returns the result word it causes
  function automatic res_word_t sched_step(logic cmd, logic [JOB_LEN_W-1:0] len,
                                           logic [TAG_W-1:0] tag);
    res_word_t  r;
    job_entry_t e;
    int         pos;
    int         i;
    r.status = ST_DONE;
    r.len    = '0;
    r.tag    = '0;
    if (cmd == CMD_ENQ) begin
      if (shadow_q.size() >= QUEUE_DEPTH_DEF) begin
        r.status = ST_FULL;
      end else begin
        pos = shadow_q.size();
        // first entry strictly longer, so equal lengths keep arrival order
        if (shadow_mode == MODE_SJF) begin
          for (i = shadow_q.size() - 1; i >= 0; i--) begin
            if (shadow_q[i].len > len) pos = i;
          end
        end
        e.len = len;
        e.tag = tag;
        shadow_q.insert(pos, e);
      end
    end else begin
      if (shadow_q.size() == 0) begin
        r.status = ST_EMPTY;
      end else begin
        e     = shadow_q.pop_front();
        r.len = e.len;
        r.tag = e.tag;
      end
    end
    r.occ = OCC_W'(shadow_q.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, want);
  endtask

  function automatic logic [JOB_LEN_W-1:0] rand_len();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) return {6'd0, 2'($urandom_range(0, 3)), 8'h00};  // many ties
    if (pick < 52) return '0;
    if (pick < 59) return '1;
    return JOB_LEN_W'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic void add_job(logic cmd, logic [JOB_LEN_W-1:0] len, logic [TAG_W-1:0] tag);
    step_t s;
    s.kind = ACT_JOB;
    s.cmd  = cmd;
    s.len  = len;
    s.tag  = tag;
    s.mode = MODE_FIFO;
    pending.push_back(s);
  endfunction

  function automatic void add_ctrl(step_kind_e kind, logic mode);
    step_t s;
    s.kind = kind;
    s.cmd  = CMD_ENQ;
    s.len  = '0;
    s.tag  = '0;
    s.mode = mode;
    pending.push_back(s);
  endfunction

  // driver: job words and mode writes, with random gaps
  always @(posedge clk_i) begin
    step_t act;
    logic  res_moving;
    logic  job_v;
    logic  cfg_v;
    if (!rst_ni) begin
      job_if.valid <= 1'b0;
      cfg_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (job_if.valid && job_if.ready)
        due_results.push_back(sched_step(job_if.cmd, job_if.job_length, job_if.job_tag));
      if (cfg_if.valid && cfg_if.ready) shadow_mode = cfg_if.queue_mode;
      res_moving = res_if.valid && res_if.ready;
      if (!((job_if.valid && !job_if.ready) || (cfg_if.valid && !cfg_if.ready))) begin
        job_v = 1'b0;
        cfg_v = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (!calm_tail && cyc[7:6] != 2'b11 && $urandom_range(0, 11) == 0) begin
          send_gap = $urandom_range(1, 18) - 1;
        end else if (pending.size() > 0) begin
          act = pending[0];
          case (act.kind)
            ACT_JOB: begin
              void'(pending.pop_front());
              job_v             = 1'b1;
              job_if.cmd        <= act.cmd;
              job_if.job_length <= act.len;
              job_if.job_tag    <= act.tag;
            end
            ACT_MODE: begin
              // mode register only changes with nothing in flight
              if (due_results.size() == 0 && !res_moving) begin
                void'(pending.pop_front());
                cfg_v             = 1'b1;
                cfg_if.queue_mode <= act.mode;
              end
            end
            default: begin
              if (due_results.size() == 0 && !res_moving) void'(pending.pop_front());
            end
          endcase
        end
        job_if.valid <= job_v;
        cfg_if.valid <= cfg_v;
      end
    end
    calm_tail <= (pending.size() < 60);
  end

  // monitor: result words against the oldest prediction, with random stalls
  always @(posedge clk_i) begin
    res_word_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("result word with none pending", 32'(res_if.status), 0);
        end else begin
          want = due_results.pop_front();
          if (res_if.status !== want.status)
            report_mismatch("status", 32'(res_if.status), 32'(want.status));
          if (res_if.out_job_length !== want.len)
            report_mismatch("out_job_length", 32'(res_if.out_job_length), 32'(want.len));
          if (res_if.out_job_tag !== want.tag)
            report_mismatch("out_job_tag", 32'(res_if.out_job_tag), 32'(want.tag));
          if (res_if.occupancy !== want.occ)
            report_mismatch("occupancy", 32'(res_if.occupancy), 32'(want.occ));
        end
      end
      if (sink_stall == 0 && !calm_tail && cyc[7:6] != 2'b00 && $urandom_range(0, 9) == 0)
        sink_stall = $urandom_range(1, 18);
      if (sink_stall > 0) begin
        sink_stall--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((job_if.valid && job_if.ready) || (cfg_if.valid && cfg_if.ready) ||
          (res_if.valid && res_if.ready) ||
          (pending.size() == 0 && due_results.size() == 0 && !job_if.valid && !cfg_if.valid))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    int unsigned rand_items;
    int unsigned enq_pct;
    int unsigned burst;
    rst_ni            = 1'b0;
    job_if.valid      = 1'b0;
    job_if.cmd        = CMD_ENQ;
    job_if.job_length = '0;
    job_if.job_tag    = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.queue_mode = MODE_FIFO;
    res_if.ready      = 1'b0;

    // directed: empty dequeue, sjf ties at the head, full drop, mode switch with entries held
    add_job(CMD_DEQ, 16'hFFFF, 16'hFFFF);
    add_ctrl(ACT_MODE, MODE_SJF);
    add_job(CMD_ENQ, 16'h0100, 16'h0001);
    add_job(CMD_ENQ, 16'h0100, 16'h0002);
    add_job(CMD_ENQ, 16'h0000, 16'h0000);
    add_job(CMD_ENQ, 16'hFFFF, 16'hFFFF);
    add_job(CMD_ENQ, 16'h0000, 16'h0003);
    repeat (11) add_job(CMD_ENQ, rand_len(), TAG_W'($urandom_range(0, 16'hFFFF)));
    add_job(CMD_ENQ, 16'h1234, 16'hABCD);
    add_ctrl(ACT_MODE, MODE_FIFO);
    add_job(CMD_DEQ, 16'h0000, 16'h0000);
    add_job(CMD_DEQ, 16'hFFFF, 16'hFFFF);
    add_job(CMD_ENQ, 16'h0080, 16'h5555);
    add_ctrl(ACT_MODE, MODE_SJF);
    add_job(CMD_ENQ, 16'h0080, 16'hAAAA);
    add_ctrl(ACT_DRAIN, MODE_FIFO);

    // random phases, each with its own enqueue share so the queue swings full and empty
    rand_items = 0;
    while (rand_items < 450) begin
      case ($urandom_range(0, 2))
        0:       enq_pct = 25;
        1:       enq_pct = 50;
        default: enq_pct = 80;
      endcase
      if ($urandom_range(0, 3) != 0) add_ctrl(ACT_MODE, 1'($urandom_range(0, 1)));
      else add_ctrl(ACT_DRAIN, MODE_FIFO);
      burst = $urandom_range(20, 60);
      repeat (burst) begin
        add_job(($urandom_range(0, 99) < enq_pct) ? CMD_ENQ : CMD_DEQ, rand_len(),
                TAG_W'($urandom_range(0, 16'hFFFF)));
        rand_items++;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    @(negedge clk_i);
    while (pending.size() != 0 || due_results.size() != 0 || job_if.valid || cfg_if.valid)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
